>>> rtl/core/ccfp_pkg.sv
`timescale 1ns / 1ps

package ccfp_pkg;

   localparam int FRAME_BUFFER_DEPTH_DEF = 32;

   localparam int BYTE_W = 8;
   localparam int PS_W   = 2;
   localparam int EV_W   = 4;

   // special bytes on the line
   localparam logic [BYTE_W-1:0] BYTE_ACK   = 8'hC5;
   localparam logic [BYTE_W-1:0] BYTE_START = 8'h3D;

   // command codes
   localparam logic [BYTE_W-1:0] CMD_PLAY     = 8'h13;
   localparam logic [BYTE_W-1:0] CMD_PAUSE    = 8'h1C;
   localparam logic [BYTE_W-1:0] CMD_STANDBY  = 8'h19;
   localparam logic [BYTE_W-1:0] CMD_TOGGLE   = 8'h24;
   localparam logic [BYTE_W-1:0] CMD_PING     = 8'h86;
   localparam logic [BYTE_W-1:0] CMD_VERSION  = 8'h07;
   localparam logic [BYTE_W-1:0] CMD_TRACK    = 8'h17;
   localparam logic [BYTE_W-1:0] CMD_PREPARE  = 8'h2C;
   localparam logic [BYTE_W-1:0] CMD_DISC     = 8'h26;
   localparam logic [BYTE_W-1:0] CMD_FORWARD  = 8'h20;
   localparam logic [BYTE_W-1:0] CMD_REWIND   = 8'h21;
   localparam logic [BYTE_W-1:0] CMD_PREV_EXT = 8'h22;

   // argument values
   localparam logic [BYTE_W-1:0] ARG_VERSION = 8'h31;
   localparam logic [BYTE_W-1:0] ARG_ONE     = 8'h01;
   localparam logic [BYTE_W-1:0] ARG_TWO     = 8'h02;
   localparam logic [BYTE_W-1:0] ARG_ALL     = 8'hFF;
   localparam logic [BYTE_W-1:0] ARG_SEEK    = 8'h0A;

   // frame lengths that carry a command
   localparam logic [BYTE_W-1:0] LEN_ONE   = 8'd1;
   localparam logic [BYTE_W-1:0] LEN_TWO   = 8'd2;
   localparam logic [BYTE_W-1:0] LEN_THREE = 8'd3;

   // player modes
   localparam logic [PS_W-1:0] PS_PLAYING = 2'd1;
   localparam logic [PS_W-1:0] PS_STANDBY = 2'd2;

   // event codes
   localparam logic [EV_W-1:0] EV_NONE    = 4'd0;
   localparam logic [EV_W-1:0] EV_PLAY    = 4'd1;
   localparam logic [EV_W-1:0] EV_PAUSE   = 4'd2;
   localparam logic [EV_W-1:0] EV_STANDBY = 4'd3;
   localparam logic [EV_W-1:0] EV_NEXT    = 4'd4;
   localparam logic [EV_W-1:0] EV_PREV    = 4'd5;
   localparam logic [EV_W-1:0] EV_PREPARE = 4'd6;
   localparam logic [EV_W-1:0] EV_DISC    = 4'd7;
   localparam logic [EV_W-1:0] EV_FORWARD = 4'd8;
   localparam logic [EV_W-1:0] EV_REWIND  = 4'd9;

   typedef struct packed {
      logic            version_reply;
      logic            ping;
      logic [EV_W-1:0] event_res;
   } decode_type;

   typedef struct packed {
      logic            ack_seen;
      logic            send_ack;
      logic            checksum_error;
      logic            overflow_drop;
      logic            version_reply;
      logic            ping;
      logic [EV_W-1:0] event_res;
   } result_type;

endpackage

>>> rtl/core/ccfp_decode.sv
`timescale 1ns / 1ps

module ccfp_decode (
   input  logic [ccfp_pkg::BYTE_W-1:0] frame_length,
   input  logic [ccfp_pkg::BYTE_W-1:0] command_byte,
   input  logic [ccfp_pkg::BYTE_W-1:0] first_argument,
   input  logic [ccfp_pkg::BYTE_W-1:0] second_argument,
   input  logic [ccfp_pkg::PS_W-1:0]   player_state,
   output ccfp_pkg::decode_type        dec
);
   import ccfp_pkg::*;

   always_comb begin
      dec = '0;
      if (frame_length == LEN_ONE) begin
         if (command_byte == CMD_PLAY) begin
            dec.event_res = EV_PLAY;
         end else if (command_byte == CMD_PAUSE) begin
            dec.event_res = EV_PAUSE;
         end else if (command_byte == CMD_STANDBY) begin
            dec.event_res = EV_STANDBY;
         end else if (command_byte == CMD_TOGGLE) begin
            dec.event_res = (player_state == PS_PLAYING) ? EV_PAUSE : EV_PLAY;
         end else if (command_byte == CMD_PING) begin
            // a ping while in standby wakes the player
            dec.ping      = 1'b1;
            dec.event_res = (player_state == PS_STANDBY) ? EV_PLAY : EV_NONE;
         end
      end else if (frame_length == LEN_TWO) begin
         if (command_byte == CMD_VERSION && first_argument == ARG_VERSION) begin
            dec.version_reply = 1'b1;
         end else if (command_byte == CMD_TRACK && first_argument == ARG_ONE) begin
            dec.event_res = EV_NEXT;
         end else if (command_byte == CMD_TRACK && first_argument == ARG_TWO) begin
            dec.event_res = EV_PREV;
         end else if (command_byte == CMD_PREPARE && first_argument == ARG_ALL) begin
            dec.event_res = EV_PREPARE;
         end else if (command_byte == CMD_DISC) begin
            dec.event_res = EV_DISC;
         end else if (command_byte == CMD_FORWARD && first_argument == ARG_SEEK) begin
            dec.event_res = EV_FORWARD;
         end else if (command_byte == CMD_REWIND && first_argument == ARG_SEEK) begin
            dec.event_res = EV_REWIND;
         end
      end else if (frame_length == LEN_THREE) begin
         if (command_byte == CMD_PREV_EXT && first_argument == ARG_ONE
             && second_argument == ARG_TWO) begin
            dec.event_res = EV_PREV;
         end
      end
   end

endmodule

>>> rtl/core/ccfp_tracker.sv
`timescale 1ns / 1ps

module ccfp_tracker #(
   parameter int FRAME_BUFFER_DEPTH = ccfp_pkg::FRAME_BUFFER_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [ccfp_pkg::BYTE_W-1:0] rx_byte,
   input  logic [ccfp_pkg::PS_W-1:0]   player_state,
   output ccfp_pkg::result_type        res
);
   import ccfp_pkg::*;

   localparam int CNT_W = $clog2(FRAME_BUFFER_DEPTH);
   localparam int LEN_W = BYTE_W + 1;
   localparam int CMP_W = (CNT_W + 1 > LEN_W) ? CNT_W + 1 : LEN_W;

   logic [CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0] running_xor_ff, running_xor_in;
   logic [BYTE_W-1:0] frame_length_ff, frame_length_in;
   logic [BYTE_W-1:0] command_byte_ff, command_byte_in;
   logic [BYTE_W-1:0] first_argument_ff, first_argument_in;
   logic [BYTE_W-1:0] second_argument_ff, second_argument_in;

   logic [CMP_W-1:0] count;
   logic [CMP_W-1:0] frame_end;
   logic             frame_done;
   decode_type       dec;

   ccfp_decode u_decode (
      .frame_length    (frame_length_ff),
      .command_byte    (command_byte_ff),
      .first_argument  (first_argument_ff),
      .second_argument (second_argument_ff),
      .player_state    (player_state),
      .dec             (dec)
   );

   assign count      = CMP_W'(byte_count_ff) + CMP_W'(1);
   assign frame_end  = CMP_W'(frame_length_ff) + CMP_W'(4);
   // length is taken at position two, so the stored value is valid from count four on
   assign frame_done = (count >= CMP_W'(4)) && (count == frame_end);

   always_comb begin
      res                = '0;
      byte_count_in      = byte_count_ff;
      running_xor_in     = running_xor_ff;
      frame_length_in    = frame_length_ff;
      command_byte_in    = command_byte_ff;
      first_argument_in  = first_argument_ff;
      second_argument_in = second_argument_ff;

      if (byte_count_ff == '0) begin
         if (rx_byte == BYTE_ACK) begin
            res.ack_seen = 1'b1;
         end else if (rx_byte == BYTE_START) begin
            running_xor_in = rx_byte;
            byte_count_in  = CNT_W'(1);
         end
      end else begin
         case (byte_count_ff)
            CNT_W'(2): frame_length_in    = rx_byte;
            CNT_W'(3): command_byte_in    = rx_byte;
            CNT_W'(4): first_argument_in  = rx_byte;
            CNT_W'(5): second_argument_in = rx_byte;
            default: ;
         endcase

         if (frame_done) begin
            if (running_xor_ff == rx_byte) begin
               res.send_ack      = 1'b1;
               res.version_reply = dec.version_reply;
               res.ping          = dec.ping;
               res.event_res     = dec.event_res;
            end else begin
               res.checksum_error = 1'b1;
            end
            byte_count_in  = '0;
            running_xor_in = '0;
         end else if (count >= CMP_W'(FRAME_BUFFER_DEPTH)) begin
            res.overflow_drop = 1'b1;
            byte_count_in     = '0;
            running_xor_in    = '0;
         end else begin
            running_xor_in = running_xor_ff ^ rx_byte;
            byte_count_in  = count[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         running_xor_ff <= '0;
      end else if (accept) begin
         byte_count_ff  <= byte_count_in;
         running_xor_ff <= running_xor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         frame_length_ff    <= frame_length_in;
         command_byte_ff    <= command_byte_in;
         first_argument_ff  <= first_argument_in;
         second_argument_ff <= second_argument_in;
      end
   end

endmodule

>>> rtl/core/changer_command_frame_parser_unit.sv
`timescale 1ns / 1ps

// channel  | dir | tdata fields (lsb first)                               | tuser | tlast
// req_     | in  | rx_byte[7:0], player_state[9:8], zero[15:10]           | -     | -
// rsp_     | out | ack_seen, send_ack, checksum_error, overflow_drop,     | -     | -
//          |     | version_reply, ping, event_res[9:6], zero[15:10]       |       |
//
// one byte per cycle while the response is not stalled: a beat is parsed in the cycle it is
// taken and its result sits in the output register on the next cycle.
// every request beat yields exactly one response beat.
// req_tready stays high while the output register is empty or being drained,
// so a stalled response holds off only the following request.
// synchronous reset clears the frame position, running xor and output valid.

module changer_command_frame_parser_unit #(
   parameter int FRAME_BUFFER_DEPTH = ccfp_pkg::FRAME_BUFFER_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_byte[7:0], player_state[9:8]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // ack_seen, send_ack, checksum_error, overflow_drop,
                                    // version_reply, ping, event_res[9:6]
);
   import ccfp_pkg::*;

   logic       accept;
   result_type res;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   ccfp_tracker #(
      .FRAME_BUFFER_DEPTH (FRAME_BUFFER_DEPTH)
   ) u_tracker (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_tdata[BYTE_W-1:0]),
      .player_state (req_tdata[BYTE_W+PS_W-1:BYTE_W]),
      .res          (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff.event_res, rsp_ff.ping, rsp_ff.version_reply,
                        rsp_ff.overflow_drop, rsp_ff.checksum_error, rsp_ff.send_ack,
                        rsp_ff.ack_seen};

   // at most one frame outcome per beat
   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_ff.ack_seen, rsp_ff.send_ack,
                                 rsp_ff.checksum_error, rsp_ff.overflow_drop}))
      else $error("more than one frame outcome in a response beat");

   // decoded commands only come with a good checksum
   a_decode_needs_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.version_reply || rsp_ff.ping
                        || rsp_ff.event_res != EV_NONE)) |-> rsp_ff.send_ack)
      else $error("command decoded without a good frame");

   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.event_res <= EV_REWIND))
      else $error("event code out of range");

   // every accepted beat shows up as a response on the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted beat produced no response");

endmodule

>>> verif/frame_parser_checker.sv
`timescale 1ns / 1ps

module frame_parser_checker
   import ccfp_pkg::*;
#(
   parameter int DEPTH = FRAME_BUFFER_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_byte[7:0], player_state[9:8]

   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // ack_seen, send_ack, checksum_error, overflow_drop,
                                    // version_reply, ping, event_res[9:6]

   output int          mismatch_count,
   output int          pending_count,
   output int          good_frames,
   output int          bad_frames,
   output int          dropped_frames
);

   localparam int POS_W = $clog2(DEPTH);

   // parser state as the block keeps it
   logic [POS_W-1:0]  byte_pos;
   logic [BYTE_W-1:0] frame_xor;
   logic [BYTE_W-1:0] frame_len;
   logic [BYTE_W-1:0] cmd;
   logic [BYTE_W-1:0] arg1;
   logic [BYTE_W-1:0] arg2;

   result_type expected_q[$];
   int errors;
   int n_good;
   int n_bad;
   int n_drop;

   function automatic decode_type decode_command(logic [PS_W-1:0] ps);
      decode_type d;
      d = '0;
      if (frame_len == LEN_ONE) begin
         if (cmd == CMD_PLAY) d.event_res = EV_PLAY;
         else if (cmd == CMD_PAUSE) d.event_res = EV_PAUSE;
         else if (cmd == CMD_STANDBY) d.event_res = EV_STANDBY;
         else if (cmd == CMD_TOGGLE) d.event_res = (ps == PS_PLAYING) ? EV_PAUSE : EV_PLAY;
         else if (cmd == CMD_PING) begin
            d.ping = 1'b1;
            if (ps == PS_STANDBY) d.event_res = EV_PLAY;
         end
      end else if (frame_len == LEN_TWO) begin
         if (cmd == CMD_VERSION && arg1 == ARG_VERSION) d.version_reply = 1'b1;
         else if (cmd == CMD_TRACK && arg1 == ARG_ONE) d.event_res = EV_NEXT;
         else if (cmd == CMD_TRACK && arg1 == ARG_TWO) d.event_res = EV_PREV;
         else if (cmd == CMD_PREPARE && arg1 == ARG_ALL) d.event_res = EV_PREPARE;
         else if (cmd == CMD_DISC) d.event_res = EV_DISC;
         else if (cmd == CMD_FORWARD && arg1 == ARG_SEEK) d.event_res = EV_FORWARD;
         else if (cmd == CMD_REWIND && arg1 == ARG_SEEK) d.event_res = EV_REWIND;
      end else if (frame_len == LEN_THREE) begin
         if (cmd == CMD_PREV_EXT && arg1 == ARG_ONE && arg2 == ARG_TWO) d.event_res = EV_PREV;
      end
      return d;
   endfunction

   function automatic result_type parse_byte(logic [BYTE_W-1:0] b, logic [PS_W-1:0] ps);
      result_type r;
      decode_type d;
      logic [POS_W:0] count;
      r = '0;
      if (byte_pos == 0) begin
         if (b == BYTE_ACK) begin
            r.ack_seen = 1'b1;
         end else if (b == BYTE_START) begin
            frame_xor = b;
            byte_pos  = POS_W'(1);
         end
         return r;
      end
      case (byte_pos)
         2: frame_len = b;
         3: cmd = b;
         4: arg1 = b;
         5: arg2 = b;
         default: ;
      endcase
      count = {1'b0, byte_pos} + (POS_W+1)'(1);
      // the checksum byte itself is compared, not folded in
      if (count >= 4 && int'(count) == int'(frame_len) + 4) begin
         if (frame_xor == b) begin
            d = decode_command(ps);
            r.send_ack      = 1'b1;
            r.version_reply = d.version_reply;
            r.ping          = d.ping;
            r.event_res     = d.event_res;
         end else begin
            r.checksum_error = 1'b1;
         end
         byte_pos  = '0;
         frame_xor = '0;
         return r;
      end
      frame_xor = frame_xor ^ b;
      if (int'(count) >= DEPTH) begin
         r.overflow_drop = 1'b1;
         byte_pos  = '0;
         frame_xor = '0;
      end else begin
         byte_pos = count[POS_W-1:0];
      end
      return r;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         byte_pos  = '0;
         frame_xor = '0;
         frame_len = '0;
         cmd       = '0;
         arg1      = '0;
         arg2      = '0;
         expected_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_q.push_back(parse_byte(req_tdata[7:0], req_tdata[9:8]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("response beat %h with nothing expected", rsp_tdata);
               errors++;
            end else begin
               want = expected_q.pop_front();
               check_field("ack_seen", int'(want.ack_seen), int'(rsp_tdata[0]));
               check_field("send_ack", int'(want.send_ack), int'(rsp_tdata[1]));
               check_field("checksum_error", int'(want.checksum_error), int'(rsp_tdata[2]));
               check_field("overflow_drop", int'(want.overflow_drop), int'(rsp_tdata[3]));
               check_field("version_reply", int'(want.version_reply), int'(rsp_tdata[4]));
               check_field("ping", int'(want.ping), int'(rsp_tdata[5]));
               check_field("event_res", int'(want.event_res), int'(rsp_tdata[9:6]));
               check_field("pad", 0, int'(rsp_tdata[15:10]));
               n_good += want.send_ack;
               n_bad  += want.checksum_error;
               n_drop += want.overflow_drop;
            end
         end
      end
      pending_count  <= expected_q.size();
      mismatch_count <= errors;
      good_frames    <= n_good;
      bad_frames     <= n_bad;
      dropped_frames <= n_drop;
   end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ccfp_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int TARGET_ITEMS = 500;

   typedef enum int {
      K_PLAY, K_PAUSE, K_STANDBY, K_TOGGLE, K_PING, K_VERSION, K_NEXT, K_PREV,
      K_PREPARE, K_DISC, K_FORWARD, K_REWIND, K_PREV_EXT, K_NEAR_TWO, K_NEAR_THREE,
      K_COUNT
   } cmd_kind_e;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata  = '0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [15:0] rsp_tdata;

   int mismatches;
   int pending;
   int good_frames;
   int bad_frames;
   int dropped_frames;
   int item_count  = 0;
   int beat_count  = 0;
   int cycle_count = 0;
   bit steady      = 1'b0;

   logic [BYTE_W-1:0] frame_body[$];
   logic [PS_W-1:0]   frame_ps;

   changer_command_frame_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   frame_parser_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatches),
      .pending_count  (pending),
      .good_frames    (good_frames),
      .bad_frames     (bad_frames),
      .dropped_frames (dropped_frames)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 24);
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   task automatic send_beat(input logic [BYTE_W-1:0] b, input logic [PS_W-1:0] ps);
      if (!steady && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, ps, b};
      do @(posedge clock); while (!req_tready);
      beat_count++;
   endtask

   // start, sequence, length, frame_body, then, when with_sum is set, the xor of all of them (spoiled if corrupt)
   task automatic send_frame(input logic [BYTE_W-1:0] len, input bit with_sum, input bit corrupt);
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] seq;
      seq = 8'($urandom_range(255));
      sum = BYTE_START ^ seq ^ len;
      foreach (frame_body[i]) sum ^= frame_body[i];
      if (corrupt) sum ^= 8'($urandom_range(1, 255));
      send_beat(BYTE_START, frame_ps);
      send_beat(seq, frame_ps);
      send_beat(len, frame_ps);
      foreach (frame_body[i]) send_beat(frame_body[i], frame_ps);
      if (with_sum) send_beat(sum, frame_ps);
      item_count += 3 + frame_body.size() + (with_sum ? 1 : 0);
   endtask

   task automatic send_command(input cmd_kind_e kind);
      frame_body.delete();
      case (kind)
         K_PLAY:    frame_body.push_back(CMD_PLAY);
         K_PAUSE:   frame_body.push_back(CMD_PAUSE);
         K_STANDBY: frame_body.push_back(CMD_STANDBY);
         K_TOGGLE:  frame_body.push_back(CMD_TOGGLE);
         K_PING:    frame_body.push_back(CMD_PING);
         K_VERSION: begin
            frame_body.push_back(CMD_VERSION);
            frame_body.push_back(ARG_VERSION);
         end
         K_NEXT: begin
            frame_body.push_back(CMD_TRACK);
            frame_body.push_back(ARG_ONE);
         end
         K_PREV: begin
            frame_body.push_back(CMD_TRACK);
            frame_body.push_back(ARG_TWO);
         end
         K_PREPARE: begin
            frame_body.push_back(CMD_PREPARE);
            frame_body.push_back(ARG_ALL);
         end
         K_DISC: begin
            frame_body.push_back(CMD_DISC);
            frame_body.push_back(8'($urandom_range(255)));
         end
         K_FORWARD: begin
            frame_body.push_back(CMD_FORWARD);
            frame_body.push_back(ARG_SEEK);
         end
         K_REWIND: begin
            frame_body.push_back(CMD_REWIND);
            frame_body.push_back(ARG_SEEK);
         end
         K_PREV_EXT: begin
            frame_body.push_back(CMD_PREV_EXT);
            frame_body.push_back(ARG_ONE);
            frame_body.push_back(ARG_TWO);
         end
         K_NEAR_TWO: begin
            // known two-byte command with an argument that mostly misses
            case ($urandom_range(4))
               0: frame_body.push_back(CMD_VERSION);
               1: frame_body.push_back(CMD_TRACK);
               2: frame_body.push_back(CMD_PREPARE);
               3: frame_body.push_back(CMD_FORWARD);
               default: frame_body.push_back(CMD_REWIND);
            endcase
            frame_body.push_back(8'($urandom_range(255)));
         end
         default: begin
            frame_body.push_back(CMD_PREV_EXT);
            frame_body.push_back(8'($urandom_range(3)));
            frame_body.push_back(8'($urandom_range(3)));
         end
      endcase
      send_frame(8'(frame_body.size()), 1'b1, 1'b0);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int pick;
      int n;
      bit mid_drained;
      logic [BYTE_W-1:0] len;
      mid_drained = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // acknowledge and stray bytes at frame start, field extremes
      send_beat(BYTE_ACK, 2'd0);
      send_beat(8'h00, 2'd0);
      send_beat(8'hFF, 2'd3);
      item_count += 3;
      frame_ps = 2'd3;
      frame_body.delete();
      send_frame(8'd0, 1'b1, 1'b0);
      frame_body.delete();
      frame_body.push_back(CMD_PLAY);
      send_frame(LEN_ONE, 1'b1, 1'b1);
      frame_ps = PS_PLAYING;
      send_command(K_TOGGLE);
      frame_ps = PS_STANDBY;
      send_command(K_PING);
      frame_ps = 2'd0;
      frame_body.delete();
      frame_body.push_back(8'hFF);
      send_frame(LEN_ONE, 1'b1, 1'b0);
      drain();

      while (item_count < TARGET_ITEMS) begin
         steady <= (item_count >= 200 && item_count < 300);
         if (!mid_drained && item_count >= 350) begin
            drain();
            mid_drained = 1'b1;
         end
         frame_ps = 2'($urandom_range(3));
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_command(cmd_kind_e'($urandom_range(0, K_COUNT - 1)));
         end else if (pick < 65) begin
            frame_body.delete();
            n = $urandom_range(0, 6);
            repeat (n) frame_body.push_back(8'($urandom_range(255)));
            send_frame(8'(n), 1'b1, 1'b0);
         end else if (pick < 72) begin
            frame_body.delete();
            n = $urandom_range(0, 3);
            repeat (n) frame_body.push_back(8'($urandom_range(255)));
            send_frame(8'(n), 1'b1, 1'b1);
         end else if (pick < 76) begin
            frame_body.delete();
            if ($urandom_range(1)) begin
               // too long for the buffer: cut off at the depth
               len = 8'($urandom_range(FRAME_BUFFER_DEPTH_DEF - 3, 255));
               repeat (FRAME_BUFFER_DEPTH_DEF - 3) frame_body.push_back(8'($urandom_range(255)));
               send_frame(len, 1'b0, 1'b0);
            end else begin
               len = 8'($urandom_range(20, FRAME_BUFFER_DEPTH_DEF - 4));
               repeat (len) frame_body.push_back(8'($urandom_range(255)));
               send_frame(len, 1'b1, 1'($urandom_range(1)));
            end
         end else if (pick < 86) begin
            send_beat(8'($urandom_range(255)), 2'($urandom_range(3)));
            item_count++;
         end else if (pick < 92) begin
            send_beat(BYTE_ACK, 2'($urandom_range(3)));
            item_count++;
         end else begin
            // start of a frame followed by junk, throws the framing off
            send_beat(BYTE_START, frame_ps);
            n = $urandom_range(1, 5);
            repeat (n) send_beat(8'($urandom_range(255)), 2'($urandom_range(3)));
            item_count += 1 + n;
         end
      end

      drain();
      repeat (4) @(posedge clock);
      $display("summary: %0d request beats in %0d cycles", beat_count, cycle_count);
      $display("summary: %0d good frames, %0d checksum errors, %0d dropped frames",
               good_frames, bad_frames, dropped_frames);
      if (mismatches == 0 && pending == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
